// File: rtl/core/kmc_pkg.sv
// ----------------------------------------------------------------------------
// kmc_pkg: shared types and constants for the spanning tree cost block
// Holds the store sizes, field widths, the edge record and the sequencer states.
// ----------------------------------------------------------------------------
package kmc_pkg;

    localparam int MaxNodes   = 1024;
    localparam int MaxEdges   = 4096;
    localparam int NodeBits   = 10;
    localparam int EdgeAddrW  = 12;
    localparam int EdgeCntW   = 13;
    localparam int CountW     = 11;
    localparam int WeightBits = 32;
    localparam int CostW      = 44;

    localparam logic [CountW-1:0]   NodesMax  = 11'd1024;
    localparam logic [EdgeCntW-1:0] EdgesMax  = 13'd4096;
    localparam logic [NodeBits-1:0] LastNode  = 10'd1023;

    // one stored edge
    typedef struct packed {
        logic [NodeBits-1:0]          a;
        logic [NodeBits-1:0]          b;
        logic signed [WeightBits-1:0] w;
    } t_edge;

    // sequencer states, one-hot
    typedef enum logic [21:0] {
        S_CLR   = 22'h000001,
        S_IDLE  = 22'h000002,
        S_PASS  = 22'h000004,
        S_RUN   = 22'h000008,
        S_LDI   = 22'h000010,
        S_LDIW  = 22'h000020,
        S_LDJ   = 22'h000040,
        S_LDJW  = 22'h000080,
        S_MRG   = 22'h000100,
        S_KRD   = 22'h000200,
        S_KRW   = 22'h000400,
        S_FRD   = 22'h000800,
        S_FW    = 22'h001000,
        S_CRD   = 22'h002000,
        S_CW    = 22'h004000,
        S_SRA   = 22'h008000,
        S_SRAW  = 22'h010000,
        S_SRB   = 22'h020000,
        S_SRBW  = 22'h040000,
        S_KNEXT = 22'h080000,
        S_DONE  = 22'h100000,
        S_SPARE = 22'h200000
    } t_state;

endpackage

// File: rtl/core/kruskal_mst_cost.sv
// ----------------------------------------------------------------------------
// kruskal_mst_cost: minimum spanning tree cost over loaded edges
// Stores edges, merge sorts them back and forth between edge memories mem0 and mem1, then runs
// union-find by size with path compression and reports one result per graph.
// ----------------------------------------------------------------------------
// Edges are taken while idle; after the last edge the merge sort makes ceil(log2 E)
//   passes, then each edge with both ends below the node count runs a root walk and a
//   path compression walk for both ends and, when the roots differ, a union by size.
// Graphs are handled one at a time; no edge is taken until the result is out.
// Reset: synchronous active-low; a clearing pass over all 1024 nodes rebuilds the node
//   store, again after each result, and no edge is taken meanwhile.
// ----------------------------------------------------------------------------
module kruskal_mst_cost (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [kmc_pkg::CountW-1:0]         i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic [kmc_pkg::NodeBits-1:0]       i_node_a,
    input  logic [kmc_pkg::NodeBits-1:0]       i_node_b,
    input  logic signed [kmc_pkg::WeightBits-1:0] i_weight,
    input  logic                               i_last_edge,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_connected,
    output logic [kmc_pkg::EdgeCntW-1:0]       o_redundant_count,
    output logic signed [kmc_pkg::CostW-1:0]   o_total_cost
);

    kmc_pkg::t_state r_state;

    // edge memories, node memories
    kmc_pkg::t_edge mem0 [kmc_pkg::MaxEdges];
    kmc_pkg::t_edge mem1 [kmc_pkg::MaxEdges];
    logic [kmc_pkg::NodeBits-1:0] lead_mem [kmc_pkg::MaxNodes];
    logic [kmc_pkg::CountW-1:0]   size_mem [kmc_pkg::MaxNodes];

    logic [kmc_pkg::EdgeCntW-1:0] r_fill, r_width, r_lo, r_mid, r_hi, r_i, r_j, r_k, r_idx;
    logic                         r_src;
    kmc_pkg::t_edge               r_ei, r_ej, r_cur, r_rd0, r_rd1;
    logic [kmc_pkg::CountW-1:0]   r_node_count, r_sza, r_size_rd;
    logic [kmc_pkg::NodeBits-1:0] r_x, r_start, r_root, r_ra, r_rb, r_lead_rd, r_clr;
    logic                         r_side;
    logic [kmc_pkg::EdgeCntW-1:0] r_join, r_skip;
    logic [kmc_pkg::CostW-1:0]    r_cost;

    logic [kmc_pkg::EdgeAddrW-1:0] rd_addr, w_addr;
    kmc_pkg::t_edge                w_data, rdata;
    logic                          w0_en, w1_en;
    logic [kmc_pkg::NodeBits-1:0]  lrd_addr, lw_addr, lw_data, srd_addr, sw_addr;
    logic                          lw_en, sw_en;
    logic [kmc_pkg::CountW-1:0]    sw_data, eff_nodes;
    logic [kmc_pkg::EdgeCntW:0]    sum_mid, sum_hi;
    logic                          take_j, a_big;
    logic [kmc_pkg::CountW:0]      size_sum;

    // effective node count
    always_comb begin
        if (r_node_count == '0) begin
            eff_nodes = 11'd1;
        end else if (r_node_count > kmc_pkg::NodesMax) begin
            eff_nodes = kmc_pkg::NodesMax;
        end else begin
            eff_nodes = r_node_count;
        end
    end

    assign rdata    = r_src ? r_rd1 : r_rd0;
    assign sum_mid  = {1'b0, r_lo} + {1'b0, r_width};
    assign sum_hi   = {1'b0, r_lo} + {r_width, 1'b0};
    assign take_j   = (r_j < r_hi) && ((r_i >= r_mid) || (r_ej.w < r_ei.w));
    assign a_big    = r_sza > r_size_rd;
    assign size_sum = {1'b0, r_sza} + {1'b0, r_size_rd};
    assign o_stall  = (r_state != kmc_pkg::S_IDLE);

    // memory port selection
    always_comb begin
        rd_addr  = r_idx[kmc_pkg::EdgeAddrW-1:0];
        w_addr   = r_k[kmc_pkg::EdgeAddrW-1:0];
        w_data   = take_j ? r_ej : r_ei;
        w0_en    = 1'b0;
        w1_en    = 1'b0;
        lrd_addr = r_x;
        lw_addr  = r_x;
        lw_data  = r_root;
        lw_en    = 1'b0;
        srd_addr = r_ra;
        sw_addr  = r_ra;
        sw_data  = size_sum[kmc_pkg::CountW-1:0];
        sw_en    = 1'b0;
        case (r_state)
            kmc_pkg::S_CLR: begin
                lw_addr = r_clr;
                lw_data = r_clr;
                lw_en   = 1'b1;
                sw_addr = r_clr;
                sw_data = 11'd1;
                sw_en   = 1'b1;
            end
            kmc_pkg::S_IDLE: begin
                w_addr = r_fill[kmc_pkg::EdgeAddrW-1:0];
                w_data = '{a: i_node_a, b: i_node_b, w: i_weight};
                w0_en  = i_valid && (r_fill < kmc_pkg::EdgesMax);
            end
            kmc_pkg::S_LDI: rd_addr = r_i[kmc_pkg::EdgeAddrW-1:0];
            kmc_pkg::S_LDJ: rd_addr = r_j[kmc_pkg::EdgeAddrW-1:0];
            kmc_pkg::S_MRG: begin
                w0_en = r_src;
                w1_en = !r_src;
            end
            kmc_pkg::S_CW: lw_en = (r_lead_rd != r_root);
            kmc_pkg::S_SRB: srd_addr = r_rb;
            kmc_pkg::S_SRBW: begin
                lw_en   = 1'b1;
                sw_en   = 1'b1;
                lw_addr = a_big ? r_rb : r_ra;
                lw_data = a_big ? r_ra : r_rb;
                sw_addr = a_big ? r_ra : r_rb;
            end
            default: ;
        endcase
    end

    // edge memories
    always_ff @(posedge i_clk) begin
        if (w0_en) mem0[w_addr] <= w_data;
        r_rd0 <= mem0[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w1_en) mem1[w_addr] <= w_data;
        r_rd1 <= mem1[rd_addr];
    end

    // node memories
    always_ff @(posedge i_clk) begin
        if (lw_en) lead_mem[lw_addr] <= lw_data;
        r_lead_rd <= lead_mem[lrd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (sw_en) size_mem[sw_addr] <= sw_data;
        r_size_rd <= size_mem[srd_addr];
    end

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= kmc_pkg::NodesMax;
        end else if (i_cfg_we) begin
            r_node_count <= i_cfg_data;
        end
    end

    // result transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (r_state == kmc_pkg::S_DONE && (!o_valid || !i_stall)) begin
            o_valid           <= 1'b1;
            o_connected       <= (r_join == ({2'b00, eff_nodes} - 13'd1));
            o_redundant_count <= r_skip;
            o_total_cost      <= r_cost;
        end else if (!i_stall) begin
            o_valid <= 1'b0;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kmc_pkg::S_CLR;
            r_clr   <= '0;
            r_fill  <= '0;
            r_join  <= '0;
            r_skip  <= '0;
            r_cost  <= '0;
            r_src   <= 1'b0;
        end else begin
            case (r_state)
                // rebuild node store, clear tallies
                kmc_pkg::S_CLR: begin
                    r_clr  <= r_clr + 10'd1;
                    r_fill <= '0;
                    r_join <= '0;
                    r_skip <= '0;
                    r_cost <= '0;
                    r_src  <= 1'b0;
                    if (r_clr == kmc_pkg::LastNode) r_state <= kmc_pkg::S_IDLE;
                end
                // edge load
                kmc_pkg::S_IDLE: begin
                    if (i_valid) begin
                        if (r_fill < kmc_pkg::EdgesMax) r_fill <= r_fill + 13'd1;
                        if (i_last_edge) begin
                            r_width <= 13'd1;
                            r_state <= kmc_pkg::S_PASS;
                        end
                    end
                end
                // sort pass control
                kmc_pkg::S_PASS: begin
                    r_lo  <= '0;
                    r_idx <= '0;
                    if (r_width >= r_fill) begin
                        r_state <= (r_fill == '0) ? kmc_pkg::S_DONE : kmc_pkg::S_KRD;
                    end else begin
                        r_state <= kmc_pkg::S_RUN;
                    end
                end
                kmc_pkg::S_RUN: begin
                    if (r_lo >= r_fill) begin
                        r_src   <= !r_src;
                        r_width <= {r_width[kmc_pkg::EdgeCntW-2:0], 1'b0};
                        r_state <= kmc_pkg::S_PASS;
                    end else begin
                        r_mid <= (sum_mid > {1'b0, r_fill}) ? r_fill
                                                            : sum_mid[kmc_pkg::EdgeCntW-1:0];
                        r_hi  <= (sum_hi > {1'b0, r_fill}) ? r_fill
                                                           : sum_hi[kmc_pkg::EdgeCntW-1:0];
                        r_j   <= (sum_mid > {1'b0, r_fill}) ? r_fill
                                                            : sum_mid[kmc_pkg::EdgeCntW-1:0];
                        r_i     <= r_lo;
                        r_k     <= r_lo;
                        r_state <= kmc_pkg::S_LDI;
                    end
                end
                kmc_pkg::S_LDI: r_state <= kmc_pkg::S_LDIW;
                kmc_pkg::S_LDIW: begin
                    r_ei    <= rdata;
                    r_state <= (r_j < r_hi) ? kmc_pkg::S_LDJ : kmc_pkg::S_MRG;
                end
                kmc_pkg::S_LDJ: r_state <= kmc_pkg::S_LDJW;
                kmc_pkg::S_LDJW: begin
                    r_ej    <= rdata;
                    r_state <= kmc_pkg::S_MRG;
                end
                // one merged element per visit
                kmc_pkg::S_MRG: begin
                    r_k <= r_k + 13'd1;
                    if (take_j) r_j <= r_j + 13'd1;
                    else        r_i <= r_i + 13'd1;
                    if (r_k + 13'd1 == r_hi) begin
                        r_lo    <= r_hi;
                        r_state <= kmc_pkg::S_RUN;
                    end else if (take_j) begin
                        r_state <= (r_j + 13'd1 < r_hi) ? kmc_pkg::S_LDJ : kmc_pkg::S_MRG;
                    end else begin
                        r_state <= (r_i + 13'd1 < r_mid) ? kmc_pkg::S_LDI : kmc_pkg::S_MRG;
                    end
                end
                // fetch sorted edge
                kmc_pkg::S_KRD: r_state <= kmc_pkg::S_KRW;
                kmc_pkg::S_KRW: begin
                    r_cur   <= rdata;
                    r_x     <= rdata.a;
                    r_start <= rdata.a;
                    r_side  <= 1'b0;
                    if ({1'b0, rdata.a} >= eff_nodes || {1'b0, rdata.b} >= eff_nodes) begin
                        r_state <= kmc_pkg::S_KNEXT;
                    end else begin
                        r_state <= kmc_pkg::S_FRD;
                    end
                end
                // root walk
                kmc_pkg::S_FRD: r_state <= kmc_pkg::S_FW;
                kmc_pkg::S_FW: begin
                    if (r_lead_rd == r_x) begin
                        r_root  <= r_x;
                        r_x     <= r_start;
                        r_state <= kmc_pkg::S_CRD;
                    end else begin
                        r_x     <= r_lead_rd;
                        r_state <= kmc_pkg::S_FRD;
                    end
                end
                // path compression walk
                kmc_pkg::S_CRD: r_state <= kmc_pkg::S_CW;
                kmc_pkg::S_CW: begin
                    if (r_lead_rd != r_root) begin
                        r_x     <= r_lead_rd;
                        r_state <= kmc_pkg::S_CRD;
                    end else if (!r_side) begin
                        r_ra    <= r_root;
                        r_side  <= 1'b1;
                        r_x     <= r_cur.b;
                        r_start <= r_cur.b;
                        r_state <= kmc_pkg::S_FRD;
                    end else begin
                        r_rb <= r_root;
                        if (r_ra == r_root) begin
                            r_skip  <= r_skip + 13'd1;
                            r_state <= kmc_pkg::S_KNEXT;
                        end else begin
                            r_state <= kmc_pkg::S_SRA;
                        end
                    end
                end
                // union by size
                kmc_pkg::S_SRA: r_state <= kmc_pkg::S_SRAW;
                kmc_pkg::S_SRAW: begin
                    r_sza   <= r_size_rd;
                    r_state <= kmc_pkg::S_SRB;
                end
                kmc_pkg::S_SRB: r_state <= kmc_pkg::S_SRBW;
                kmc_pkg::S_SRBW: begin
                    r_join  <= r_join + 13'd1;
                    r_cost  <= r_cost + {{(kmc_pkg::CostW-kmc_pkg::WeightBits){
                                             r_cur.w[kmc_pkg::WeightBits-1]}},
                                         r_cur.w};
                    r_state <= kmc_pkg::S_KNEXT;
                end
                kmc_pkg::S_KNEXT: begin
                    r_idx   <= r_idx + 13'd1;
                    r_state <= (r_idx + 13'd1 == r_fill) ? kmc_pkg::S_DONE : kmc_pkg::S_KRD;
                end
                // wait for the result register
                kmc_pkg::S_DONE: begin
                    if (!o_valid || !i_stall) begin
                        r_clr   <= '0;
                        r_state <= kmc_pkg::S_CLR;
                    end
                end
                default: r_state <= kmc_pkg::S_CLR;
            endcase
        end
    end

endmodule
